// ===== design/bch_pkg.sv =====
// Shared constants, types and parity functions for the BCH (44,32) codec.
// No dependencies; every design file imports this package.
package bch_pkg;

    localparam int DATA_W = 32;
    localparam int PAR_W  = 12;
    localparam int CODE_W = DATA_W + PAR_W;

    // Depth of the word queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // Action codes
    localparam logic ACT_ENCODE = 1'b0;
    localparam logic ACT_DECODE = 1'b1;

    // Status codes
    localparam logic [1:0] ST_CLEAN = 2'd0;
    localparam logic [1:0] ST_FIXED = 2'd1;
    localparam logic [1:0] ST_FAIL  = 2'd2;

    // Parity equations, element i drives parity bit i
    localparam logic [PAR_W-1:0][DATA_W-1:0] PAR_EQ = {
        32'h9FB18B3C, 32'h4FD8C59E, 32'h27EC62CF, 32'h0C47BA5B,
        32'h99925611, 32'hD378A034, 32'h69BC501A, 32'h34DE280D,
        32'h85DE9F3A, 32'hC2EF4F9D, 32'h7EC62CF2, 32'h3F631679
    };

    typedef logic [CODE_W-1:0][PAR_W-1:0] t_hcol;

    // Word handed from front to back: codeword or received word plus syndrome
    typedef struct packed {
        logic [CODE_W-1:0] word;
        logic [PAR_W-1:0]  syn;
    } t_mid;

    // Twelve parity bits of a data word
    function automatic logic [PAR_W-1:0] parity_of(input logic [DATA_W-1:0] d);
        logic [PAR_W-1:0] p;
        p = '0;
        for (int i = 0; i < PAR_W; i++) begin
            p[i] = ^(d & PAR_EQ[i]);
        end
        return p;
    endfunction

    // Syndrome of each single-bit error (columns of the check matrix)
    function automatic t_hcol build_hcol();
        t_hcol h;
        h = '0;
        for (int a = 0; a < PAR_W; a++) begin
            h[a] = PAR_W'(1) << a;
        end
        for (int j = 0; j < DATA_W; j++) begin
            h[PAR_W + j] = parity_of(DATA_W'(1) << j);
        end
        return h;
    endfunction

    localparam t_hcol HCOL = build_hcol();

endpackage

// ===== design/bch_front.sv =====
// Front end: encodes data words or forms the syndrome of received words.
// Depends on bch_pkg.
module bch_front (
    input  logic                        i_action,
    input  logic [bch_pkg::DATA_W-1:0]  i_data_in,
    input  logic [bch_pkg::CODE_W-1:0]  i_code_in,
    output bch_pkg::t_mid               o_item
);
    import bch_pkg::*;

    logic [PAR_W-1:0] enc_par;
    logic [PAR_W-1:0] rx_par;

    // Parity over data bits of both candidate words
    assign enc_par = parity_of(i_data_in);
    assign rx_par  = parity_of(i_code_in[CODE_W-1:PAR_W]);

    // An encoded word carries a zero syndrome, so the back passes it as clean
    always_comb begin
        if (i_action == ACT_DECODE) begin
            o_item.word = i_code_in;
            o_item.syn  = i_code_in[PAR_W-1:0] ^ rx_par;
        end else begin
            o_item.word = {i_data_in, enc_par};
            o_item.syn  = '0;
        end
    end

endmodule

// ===== design/bch_mid_q.sv =====
// Short first-word-fall-through queue between front and back.
// Depends on bch_pkg.
module bch_mid_q (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bch_pkg::t_mid  i_item,
    output logic           o_full,
    input  logic           i_pop,
    output bch_pkg::t_mid  o_item,
    output logic           o_empty
);
    import bch_pkg::*;

    t_mid            r_mem [QDEPTH];
    logic [QAW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QAW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QAW:0]    r_cnt, n_cnt;
    logic            do_push, do_pop;

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd_ptr];

    // Pointer and fill count update
    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_cnt    = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Fill count never passes the depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QAW+1)'(QDEPTH)) else $error("queue count overflow");

    // Count follows the pointer distance
    a_cnt_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_ptr == r_rd_ptr + r_cnt[QAW-1:0]) else $error("queue pointers out of step");

endmodule

// ===== design/bch_back.sv =====
// Back end: decodes the syndrome into a flip mask, applies it and holds the result.
// Depends on bch_pkg.
module bch_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bch_pkg::t_mid               i_item,
    input  logic                        i_q_empty,
    output logic                        o_q_pop,
    input  logic                        i_pop,
    output logic                        o_empty,
    output logic [bch_pkg::CODE_W-1:0]  o_code_out,
    output logic [bch_pkg::PAR_W-1:0]   o_syndrome,
    output logic [1:0]                  o_status,
    output logic [1:0]                  o_bits_fixed
);
    import bch_pkg::*;

    // Decode stage
    logic               r_a_valid;
    logic [CODE_W-1:0]  r_a_word;
    logic [PAR_W-1:0]   r_a_syn;
    logic [CODE_W-1:0]  r_a_mask, n_a_mask;
    logic [1:0]         r_a_status, n_a_status;
    logic [1:0]         r_a_cnt, n_a_cnt;

    // Result stage
    logic               r_o_valid;
    logic [CODE_W-1:0]  r_o_code;
    logic [PAR_W-1:0]   r_o_syn;
    logic [1:0]         r_o_status;
    logic [1:0]         r_o_cnt;

    logic               sgl_any, pair_any;
    logic               o_ready, a_ready;

    assign o_ready = !r_o_valid || i_pop;
    assign a_ready = !r_a_valid || o_ready;
    assign o_q_pop = !i_q_empty && a_ready;

    // Match the syndrome against every single and double error syndrome.
    // A bit flips when it takes part in a matching pattern.
    always_comb begin
        n_a_mask = '0;
        sgl_any  = 1'b0;
        pair_any = 1'b0;
        for (int a = 0; a < CODE_W; a++) begin
            if (i_item.syn == HCOL[a]) begin
                n_a_mask[a] = 1'b1;
                sgl_any     = 1'b1;
            end
            for (int b = 0; b < CODE_W; b++) begin
                if (b != a && i_item.syn == (HCOL[a] ^ HCOL[b])) begin
                    n_a_mask[a] = 1'b1;
                    pair_any    = 1'b1;
                end
            end
        end
    end

    // Classify
    always_comb begin
        if (i_item.syn == '0) begin
            n_a_status = ST_CLEAN;
            n_a_cnt    = 2'd0;
        end else if (sgl_any) begin
            n_a_status = ST_FIXED;
            n_a_cnt    = 2'd1;
        end else if (pair_any) begin
            n_a_status = ST_FIXED;
            n_a_cnt    = 2'd2;
        end else begin
            n_a_status = ST_FAIL;
            n_a_cnt    = 2'd0;
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_valid <= !i_q_empty;
            end
            if (o_ready) begin
                r_o_valid <= r_a_valid;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_a_word   <= i_item.word;
            r_a_syn    <= i_item.syn;
            r_a_mask   <= n_a_mask;
            r_a_status <= n_a_status;
            r_a_cnt    <= n_a_cnt;
        end
        if (o_ready && r_a_valid) begin
            r_o_code   <= r_a_word ^ r_a_mask;
            r_o_syn    <= r_a_syn;
            r_o_status <= r_a_status;
            r_o_cnt    <= r_a_cnt;
        end
    end

    assign o_empty      = !r_o_valid;
    assign o_code_out   = r_o_code;
    assign o_syndrome   = r_o_syn;
    assign o_status     = r_o_status;
    assign o_bits_fixed = r_o_cnt;

    // Flip mask weight agrees with the reported count
    a_mask_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid |-> ($countones(r_a_mask) == 32'(r_a_cnt)))
        else $error("flip mask weight mismatch");

    // Only corrected words carry a flip mask
    a_mask_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && r_a_status != ST_FIXED |-> r_a_mask == '0)
        else $error("mask set on word not corrected");

    // Clean result has zero syndrome
    a_clean_syn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_status == ST_CLEAN |-> r_o_syn == '0)
        else $error("clean status with nonzero syndrome");

endmodule

// ===== design/bch_44_32_double_error_codec.sv =====
// BCH (44,32) double-error-correcting encoder/decoder, one word per cycle while results are popped.
// A word accepted into the queue passes through the decode stage and the result stage registers to the result ports.
// Throughput: one word per cycle while results are popped; the queue holds 4 words while results stall.
// Reset (synchronous, active low) empties the queue and the back pipeline;
// the correction logic is constant and needs no initialization.
module bch_44_32_double_error_codec (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    output logic                        o_full,
    input  logic                        i_action,
    input  logic [bch_pkg::DATA_W-1:0]  i_data_in,
    input  logic [bch_pkg::CODE_W-1:0]  i_code_in,
    input  logic                        i_pop,
    output logic                        o_empty,
    output logic [bch_pkg::CODE_W-1:0]  o_code_out,
    output logic [bch_pkg::PAR_W-1:0]   o_syndrome,
    output logic [1:0]                  o_status,
    output logic [1:0]                  o_bits_fixed
);
    import bch_pkg::*;

    t_mid  front_item;
    t_mid  q_item;
    logic  q_empty;
    logic  q_pop;

    // Encode or form syndrome
    bch_front u_front (
        .i_action  (i_action),
        .i_data_in (i_data_in),
        .i_code_in (i_code_in),
        .o_item    (front_item)
    );

    // Decoupling queue
    bch_mid_q u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_item  (front_item),
        .o_full  (o_full),
        .i_pop   (q_pop),
        .o_item  (q_item),
        .o_empty (q_empty)
    );

    // Correct and deliver
    bch_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (q_item),
        .i_q_empty    (q_empty),
        .o_q_pop      (q_pop),
        .i_pop        (i_pop),
        .o_empty      (o_empty),
        .o_code_out   (o_code_out),
        .o_syndrome   (o_syndrome),
        .o_status     (o_status),
        .o_bits_fixed (o_bits_fixed)
    );

endmodule
